// ----- rtl/fcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

   localparam logic [1:0] REG_CRC_KIND = 2'd0;
   localparam logic [1:0] REG_OP_MODE  = 2'd1;
   localparam logic [1:0] REG_CRC_SEED = 2'd2;

   localparam logic [1:0] MODE_CHECKSUM = 2'd0;
   localparam logic [1:0] MODE_VERIFY   = 2'd1;
   localparam logic [1:0] MODE_APPEND   = 2'd2;

   localparam logic        KIND_RESET = 1'b1;
   localparam logic [1:0]  MODE_RESET = MODE_VERIFY;
   localparam logic [15:0] SEED_RESET = 16'hffff;

   localparam logic [15:0] POLY_CRC16 = 16'h8408;
   localparam logic [15:0] POLY_CRC8  = 16'h008c;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic        kind;
      logic [1:0]  mode;
      logic [15:0] seed;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] crc_value;
      logic        check_ok;
      logic        run_end;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                        count;
      rsp_item_type [MAX_RESULTS-1:0]    items;
   } burst_type;

   // Reflected CRC update over one byte, bit at a time.
   function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                              input logic [7:0] data,
                                              input logic wide);
      logic [15:0] crc;
      logic [15:0] poly;
      poly = wide ? POLY_CRC16 : POLY_CRC8;
      crc  = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ poly;
         end else begin
            crc = crc >> 1;
         end
      end
      if (!wide) begin
         crc = crc & 16'h00ff;
      end
      return crc;
   endfunction

   function automatic rsp_item_type make_item(input logic [7:0] b,
                                              input logic [15:0] crc,
                                              input logic ok,
                                              input logic last);
      rsp_item_type item;
      item.out_byte  = b;
      item.crc_value = crc;
      item.check_ok  = ok;
      item.run_end   = last;
      return item;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/fcc_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fcc_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [3:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output fcc_pkg::cfg_type   cfg
);
   import fcc_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CRC_KIND: cfg_in.kind = csr_pwdata[0];
            REG_OP_MODE:  cfg_in.mode = csr_pwdata[1:0];
            REG_CRC_SEED: cfg_in.seed = csr_pwdata[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CRC_KIND: csr_prdata = {31'd0, cfg_ff.kind};
         REG_OP_MODE:  csr_prdata = {30'd0, cfg_ff.mode};
         REG_CRC_SEED: csr_prdata = {16'd0, cfg_ff.seed};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind <= KIND_RESET;
         cfg_ff.mode <= MODE_RESET;
         cfg_ff.seed <= SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/fcc_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fcc_engine (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire fcc_pkg::cfg_type cfg,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [7:0]     req_tdata,
   input  wire logic           req_tlast,
   input  wire logic           buf_free,
   output logic                load,
   output fcc_pkg::burst_type  burst
);
   import fcc_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   logic [15:0] crc_reg_ff, crc_reg_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  count_ff, count_in;

   logic        wide;
   logic [15:0] mask;
   logic        held_full;
   logic [7:0]  oldest;
   logic [15:0] base_crc;
   logic [15:0] crc_old;
   logic [15:0] crc_new;
   logic [15:0] crc_next;
   logic        ok;

   assign req_tready  = !in_valid_ff || buf_free;
   assign load        = in_valid_ff && buf_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   assign wide      = cfg.kind;
   assign mask      = wide ? 16'hffff : 16'h00ff;
   // The delay line is full once it holds as many bytes as the tail is long.
   assign held_full = wide ? (count_ff >= 2'd2) : (count_ff >= 2'd1);
   assign oldest    = wide ? held1_ff : held0_ff;
   assign base_crc  = (count_ff == 2'd0) ? (cfg.seed & mask) : (crc_reg_ff & mask);
   assign crc_old   = crc_update(base_crc, oldest, wide);
   assign crc_new   = crc_update(base_crc, in_byte_ff, wide);

   always_comb begin
      burst    = '0;
      crc_next = base_crc;
      ok       = 1'b0;
      case (cfg.mode)
         MODE_VERIFY: begin
            if (!in_last_ff) begin
               if (held_full) begin
                  crc_next = crc_old;
               end
            end else begin
               if (count_ff >= 2'd2) begin
                  crc_next = crc_old;
                  if (wide) begin
                     ok = (crc_old[7:0] == held0_ff) && (crc_old[15:8] == in_byte_ff);
                  end else begin
                     ok = (crc_old[7:0] == in_byte_ff);
                  end
               end
               burst.count    = 2'd1;
               burst.items[0] = make_item(8'h00, crc_next, ok, 1'b1);
            end
         end
         MODE_APPEND: begin
            if (!in_last_ff) begin
               if (held_full) begin
                  crc_next       = crc_old;
                  burst.count    = 2'd1;
                  burst.items[0] = make_item(oldest, crc_old, 1'b0, 1'b0);
               end
            end else if (count_ff >= 2'd2) begin
               crc_next       = crc_old;
               burst.items[0] = make_item(oldest, crc_old, 1'b0, 1'b0);
               burst.items[1] = make_item(crc_old[7:0], crc_old, 1'b0, !wide);
               burst.items[2] = make_item(crc_old[15:8], crc_old, 1'b0, 1'b1);
               burst.count    = wide ? 2'd3 : 2'd2;
            end else if (count_ff == 2'd1) begin
               // Short frame: the one held byte and the last byte pass unchanged.
               burst.items[0] = make_item(held0_ff, base_crc, 1'b0, 1'b0);
               burst.items[1] = make_item(in_byte_ff, base_crc, 1'b0, 1'b1);
               burst.count    = 2'd2;
            end else begin
               burst.items[0] = make_item(in_byte_ff, base_crc, 1'b0, 1'b1);
               burst.count    = 2'd1;
            end
         end
         default: begin
            crc_next = crc_new;
            if (in_last_ff) begin
               burst.count    = 2'd1;
               burst.items[0] = make_item(8'h00, crc_new, 1'b0, 1'b1);
            end
         end
      endcase
   end

   always_comb begin
      crc_reg_in = crc_reg_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      count_in   = count_ff;
      if (load) begin
         crc_reg_in = crc_next;
         held1_in   = held0_ff;
         held0_in   = in_byte_ff;
         if (in_last_ff) begin
            count_in = 2'd0;
         end else if (count_ff != 2'd3) begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         crc_reg_ff  <= 16'hffff;
         held0_ff    <= 8'h00;
         held1_ff    <= 8'h00;
         count_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         crc_reg_ff  <= crc_reg_in;
         held0_ff    <= held0_in;
         held1_ff    <= held1_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fcc_outbuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fcc_outbuf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire fcc_pkg::burst_type burst,
   output logic                   buf_free,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   import fcc_pkg::*;

   logic [1:0]                     count_ff, count_in;
   logic [1:0]                     idx_ff, idx_in;
   rsp_item_type [MAX_RESULTS-1:0] items_ff;
   rsp_item_type                   cur;
   logic                           take;
   logic                           final_take;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign cur        = items_ff[idx_ff];
   assign rsp_tdata  = {7'd0, cur.check_ok, cur.crc_value, cur.out_byte};
   assign rsp_tlast  = cur.run_end;

   assign take       = rsp_tvalid && rsp_tready;
   assign final_take = take && (idx_ff == count_ff - 2'd1);
   // The buffer takes a new burst when empty or when its last result leaves now.
   assign buf_free   = !rsp_tvalid || final_take;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (load) begin
         count_in = burst.count;
         idx_in   = 2'd0;
      end else if (final_take) begin
         count_in = 2'd0;
         idx_in   = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= burst.items;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/frame_crc8_crc16_checker_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction
// req_      in         one frame byte, tlast on the final byte of the frame
// rsp_      out        one result: output byte, CRC, check flag; tlast ends a frame
// csr_      in         APB register access: crc_kind, op_mode, crc_seed
//
// A byte is held in the input register and is then folded into the CRC, which
// loads its zero to three results into the output buffer; a result passes the
// input register and then the output buffer register before it is shown.
// While each byte gives at most one result and rsp_tready is high, a new byte is
// taken every cycle; otherwise the input waits until the last result is taken.
// Reset is synchronous; it empties both stages and restores the register defaults.
// A stall on rsp_tready holds the buffer and backs up into req_tready.
module frame_crc8_crc16_checker_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // [7:0] data_byte
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,    // [7:0] out_byte, [23:8] crc_value,
                                           // [24] check_ok, [31:25] zero
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import fcc_pkg::*;

   cfg_type   cfg;
   burst_type burst;
   logic      load;
   logic      buf_free;

   fcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fcc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .buf_free   (buf_free),
      .load       (load),
      .burst      (burst)
   );

   fcc_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .burst      (burst),
      .buf_free   (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
